// ----- src/spq_pkg.sv -----
package spq_pkg;

    localparam int TAG_W    = 16;
    localparam int PRI_W    = 8;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    // datapath operations
    localparam logic [1:0] OP_NONE       = 2'd0;
    localparam logic [1:0] OP_INSERT     = 2'd1;
    localparam logic [1:0] OP_DUMP_STEP  = 2'd2;
    localparam logic [1:0] OP_DUMP_EMPTY = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] item_tag;
        logic [PRI_W-1:0] item_priority;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    entry_tag;
        logic [PRI_W-1:0]    entry_priority;
        logic [POS_W-1:0]    entry_position;
        logic                last;
    } out_word_t;

    typedef struct packed {
        logic       capture;
        logic [1:0] op;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic at_last;
    } dp_status_t;

endpackage

// ----- src/spq_ctrl.sv -----
module spq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               kind,
    input  spq_pkg::dp_status_t dp_status,
    output logic               busy,
    output spq_pkg::cmd_t      cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_INSERT = 2'd1;
    localparam logic [1:0] S_DUMP   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.op      = spq_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (kind == spq_pkg::KIND_DUMP) ? S_DUMP : S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.op     = spq_pkg::OP_INSERT;
                state_next = S_IDLE;
            end
            S_DUMP:
            begin
                if (dp_status.empty)
                begin
                    cmd.op     = spq_pkg::OP_DUMP_EMPTY;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = spq_pkg::OP_DUMP_STEP;
                    if (dp_status.at_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/spq_dp.sv -----
module spq_dp
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::in_word_t   item,
    input  spq_pkg::cmd_t       cmd,
    output spq_pkg::dp_status_t dp_status,
    output logic                strobe,
    output spq_pkg::out_word_t  result
);

    localparam int TW = (TAG_BITS < spq_pkg::TAG_W) ? TAG_BITS : spq_pkg::TAG_W;
    localparam int PW = (PRIORITY_BITS < spq_pkg::PRI_W) ? PRIORITY_BITS : spq_pkg::PRI_W;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    // sorted list, front at cell 0
    logic [TW-1:0] tag_reg  [QUEUE_DEPTH];
    logic [PW-1:0] pri_reg  [QUEUE_DEPTH];
    logic [TW-1:0] tag_next [QUEUE_DEPTH];
    logic [PW-1:0] pri_next [QUEUE_DEPTH];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [TW-1:0] new_tag_reg;
    logic [PW-1:0] new_pri_reg;

    spq_pkg::out_word_t result_reg;
    spq_pkg::out_word_t result_next;
    logic               strobe_reg;
    logic               strobe_next;

    logic [QUEUE_DEPTH-1:0] greater;
    logic [QUEUE_DEPTH-1:0] gt_prev;
    logic                   full;
    logic                   do_insert;
    logic                   do_rotate;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign do_insert = (cmd.op == spq_pkg::OP_INSERT) && !full;
    assign do_rotate = (cmd.op == spq_pkg::OP_DUMP_STEP);
    assign gt_prev   = {greater[QUEUE_DEPTH-2:0], 1'b0};

    assign dp_status.empty   = (count_reg == '0);
    assign dp_status.at_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic at_count;
            logic last_cell;
            logic take_new;
            logic [TW-1:0] ins_tag;
            logic [PW-1:0] ins_pri;
            logic [TW-1:0] rot_tag;
            logic [PW-1:0] rot_pri;

            assign greater[i] = (CW'(i) < count_reg) && (pri_reg[i] > new_pri_reg);
            assign at_count   = (count_reg == CW'(i));
            assign last_cell  = (count_reg == CW'(i + 1));
            // the new entry lands in the first cell whose priority is strictly greater
            assign take_new   = (greater[i] || at_count) && !gt_prev[i];

            if (i == 0)
            begin : g_front
                assign ins_tag = take_new ? new_tag_reg : tag_reg[i];
                assign ins_pri = take_new ? new_pri_reg : pri_reg[i];
            end
            else
            begin : g_body
                assign ins_tag = gt_prev[i] ? tag_reg[i-1] :
                                 take_new   ? new_tag_reg  : tag_reg[i];
                assign ins_pri = gt_prev[i] ? pri_reg[i-1] :
                                 take_new   ? new_pri_reg  : pri_reg[i];
            end

            // rotate within the filled part so the list is back in place after a dump
            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign rot_tag = last_cell ? tag_reg[0] : tag_reg[i];
                assign rot_pri = last_cell ? pri_reg[0] : pri_reg[i];
            end
            else
            begin : g_mid
                assign rot_tag = last_cell ? tag_reg[0] : tag_reg[i+1];
                assign rot_pri = last_cell ? pri_reg[0] : pri_reg[i+1];
            end

            assign tag_next[i] = do_insert ? ins_tag : do_rotate ? rot_tag : tag_reg[i];
            assign pri_next[i] = do_insert ? ins_pri : do_rotate ? rot_pri : pri_reg[i];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            tag_reg[k] <= tag_next[k];
            pri_reg[k] <= pri_next[k];
        end
        if (cmd.capture)
        begin
            new_tag_reg <= item.item_tag[TW-1:0];
            new_pri_reg <= item.item_priority[PW-1:0];
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        result_next = '0;
        if (cmd.capture)
        begin
            idx_next = '0;
        end
        case (cmd.op)
            spq_pkg::OP_INSERT:
            begin
                strobe_next      = 1'b1;
                result_next.last = 1'b1;
                if (full)
                begin
                    result_next.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    result_next.status = spq_pkg::ST_INSERTED;
                    count_next         = count_reg + CW'(1);
                end
            end
            spq_pkg::OP_DUMP_STEP:
            begin
                strobe_next                = 1'b1;
                result_next.status         = spq_pkg::ST_ENTRY;
                result_next.entry_tag      = spq_pkg::TAG_W'(tag_reg[0]);
                result_next.entry_priority = spq_pkg::PRI_W'(pri_reg[0]);
                result_next.entry_position = spq_pkg::POS_W'(idx_reg);
                result_next.last           = dp_status.at_last;
                idx_next                   = idx_reg + IW'(1);
            end
            spq_pkg::OP_DUMP_EMPTY:
            begin
                strobe_next        = 1'b1;
                result_next.status = spq_pkg::ST_EMPTY;
                result_next.last   = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ----- src/sorted_priority_queue_core.sv -----
// sorted priority queue: entries are kept in ascending priority order, equal priorities in
// arrival order. a word is taken when start is high and busy is low. for an insert the word is
// captured, then in the insert state every cell compares against the new priority and the
// list shifts open; the result word is registered and follows in the cycle after, while the next
// word may already be taken. a dump keeps busy high while its entries are read out (or, for an
// empty queue, its empty status): each cycle the front cell is sent out while the filled part
// of the list rotates by one, so the queue is unchanged at the end. every result is shown
// for exactly one cycle with strobe high and must be taken then; there is no way to hold it off.
module sorted_priority_queue_core
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::in_word_t  item,
    output logic               strobe,
    output spq_pkg::out_word_t result
);

    spq_pkg::cmd_t       cmd;
    spq_pkg::dp_status_t dp_status;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (item.kind),
        .dp_status (dp_status),
        .busy      (busy),
        .cmd       (cmd)
    );

    spq_dp
    #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .dp_status (dp_status),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 180;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 24;

    typedef struct {
        logic                         kind;
        logic [spq_pkg::TAG_W-1:0]    tag;
        logic [spq_pkg::PRI_W-1:0]    pri;
        bit                           typed;
        logic [spq_pkg::STATUS_W-1:0] status;
    } step_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    spq_pkg::in_word_t  item;
    logic               strobe;
    spq_pkg::out_word_t result;

    // directed words; typed rows carry their single result status
    step_t script [13] = '{
        '{spq_pkg::KIND_DUMP,   16'h0000, 8'h00, 1'b1, spq_pkg::ST_EMPTY},
        '{spq_pkg::KIND_INSERT, 16'h0000, 8'hff, 1'b1, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'hffff, 8'h00, 1'b1, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_DUMP,   16'hffff, 8'hff, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'h1234, 8'h80, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'h4321, 8'h80, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'ha5a5, 8'h00, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'h5a5a, 8'hff, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'h0001, 8'h7f, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'h8000, 8'h81, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_DUMP,   16'h0000, 8'h00, 1'b0, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_INSERT, 16'hffff, 8'hff, 1'b1, spq_pkg::ST_INSERTED},
        '{spq_pkg::KIND_DUMP,   16'h0000, 8'h00, 1'b0, spq_pkg::ST_INSERTED}
    };

    // shadow copy of the sorted list
    logic [spq_pkg::TAG_W-1:0] shadow_tags [DEPTH];
    logic [spq_pkg::PRI_W-1:0] shadow_pris [DEPTH];
    int                        shadow_count;

    spq_pkg::out_word_t pending_results [$];

    bit                           typed_now;
    logic [spq_pkg::STATUS_W-1:0] typed_status;
    int                           words_taken;
    int                           burst_left;
    int                           cycle_count;
    int                           errors;
    int                           n_inserted;
    int                           n_rejected;
    int                           n_dumps;
    int                           n_checked;

    sorted_priority_queue_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void predict_queue_results(input spq_pkg::in_word_t w, input bit typed,
                                                  input logic [spq_pkg::STATUS_W-1:0] st);
        spq_pkg::out_word_t r;
        spq_pkg::out_word_t fresh [$];
        int                 slot;
        r = '0;
        if (w.kind == spq_pkg::KIND_INSERT)
        begin
            r.last = 1'b1;
            if (shadow_count >= DEPTH)
            begin
                r.status = spq_pkg::ST_FULL;
                n_rejected++;
            end
            else
            begin
                // first stored entry with a strictly greater priority
                slot = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_pris[i] > w.item_priority)
                        slot = i;
                for (int i = shadow_count; i > slot; i--)
                begin
                    shadow_tags[i] = shadow_tags[i-1];
                    shadow_pris[i] = shadow_pris[i-1];
                end
                shadow_tags[slot] = w.item_tag;
                shadow_pris[slot] = w.item_priority;
                shadow_count++;
                r.status = spq_pkg::ST_INSERTED;
                n_inserted++;
            end
            fresh.push_back(r);
        end
        else
        begin
            n_dumps++;
            if (shadow_count == 0)
            begin
                r.status = spq_pkg::ST_EMPTY;
                r.last   = 1'b1;
                fresh.push_back(r);
            end
            else
                for (int i = 0; i < shadow_count; i++)
                begin
                    r.status         = spq_pkg::ST_ENTRY;
                    r.entry_tag      = shadow_tags[i];
                    r.entry_priority = shadow_pris[i];
                    r.entry_position = i[spq_pkg::POS_W-1:0];
                    r.last           = (i == shadow_count - 1);
                    fresh.push_back(r);
                end
        end
        if (typed)
        begin
            r = '0;
            r.status = st;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end
        else
            foreach (fresh[k])
                pending_results.push_back(fresh[k]);
    endfunction

    function automatic void check_result(input spq_pkg::out_word_t got);
        spq_pkg::out_word_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result word %h", got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.entry_tag !== want.entry_tag)
        begin
            $error("entry_tag: expected %h, actual %h", want.entry_tag, got.entry_tag);
            errors++;
        end
        if (got.entry_priority !== want.entry_priority)
        begin
            $error("entry_priority: expected %h, actual %h",
                   want.entry_priority, got.entry_priority);
            errors++;
        end
        if (got.entry_position !== want.entry_position)
        begin
            $error("entry_position: expected %0d, actual %0d",
                   want.entry_position, got.entry_position);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
        end
    endfunction

    // results are checked before the new word is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                check_result(result);
            if (start && !busy)
            begin
                predict_queue_results(item, typed_now, typed_status);
                words_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int sel;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (sel < 9)
            return 0;
        if (sel < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input spq_pkg::in_word_t w, input bit typed,
                             input logic [spq_pkg::STATUS_W-1:0] st);
        int gap;
        int seen;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item         <= w;
        typed_now    <= typed;
        typed_status <= st;
        start        <= 1'b1;
        seen = words_taken;
        do
            @(negedge clk);
        while (words_taken == seen);
    endtask

    function automatic logic [spq_pkg::TAG_W-1:0] random_tag();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return spq_pkg::TAG_W'($urandom);
    endfunction

    function automatic logic [spq_pkg::PRI_W-1:0] random_pri();
        int sel;
        sel = $urandom_range(0, 9);
        // narrow range half of the time so ties are common
        if (sel < 5)
            return spq_pkg::PRI_W'($urandom_range(0, 7));
        if (sel == 5)
            return '0;
        if (sel == 6)
            return '1;
        return spq_pkg::PRI_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        spq_pkg::in_word_t w;
        int                settle;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        typed_now    = 1'b0;
        typed_status = spq_pkg::ST_INSERTED;
        words_taken  = 0;
        burst_left   = 0;
        cycle_count  = 0;
        errors       = 0;
        n_inserted   = 0;
        n_rejected   = 0;
        n_dumps      = 0;
        n_checked    = 0;
        shadow_count = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            w.kind          = script[i].kind;
            w.item_tag      = script[i].tag;
            w.item_priority = script[i].pri;
            send_word(w, script[i].typed, script[i].status);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            w.kind          = ($urandom_range(0, 9) < 6) ? spq_pkg::KIND_INSERT
                                                         : spq_pkg::KIND_DUMP;
            w.item_tag      = random_tag();
            w.item_priority = random_pri();
            send_word(w, 1'b0, spq_pkg::ST_INSERTED);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        settle = SETTLE;
        repeat (settle) @(negedge clk);

        $display("%0d inserts taken, %0d rejected on a full queue, %0d dumps",
                 n_inserted, n_rejected, n_dumps);
        $display("%0d result words checked, %0d leftover", n_checked, pending_results.size());
        if (errors == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sorted_priority_queue_core.f -----
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_priority_queue_core.sv
bench/tb_top.sv
